// ===== src/access_credential_table_core_assert.svh =====
`ifndef ACCESS_CREDENTIAL_TABLE_CORE_ASSERT_SVH
`define ACCESS_CREDENTIAL_TABLE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ACT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ACT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/act_pkg.sv =====
package act_pkg;

  localparam int ENTRIES_DEF = 16;

  localparam logic [7:0]  EMPTY_BYTE  = 8'hFF;
  localparam logic [7:0]  CHAR_ZERO   = 8'h30;
  localparam logic [7:0]  CHAR_ONE    = 8'h31;
  localparam logic [31:0] ADMIN_RESET = 32'h3030_3030;

  typedef enum logic [2:0] {
    OP_ENROLL = 3'd0,
    OP_REMOVE = 3'd1,
    OP_TOGGLE = 3'd2,
    OP_QUERY  = 3'd3,
    OP_CLASS  = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  localparam logic [1:0] OUT_OK        = 2'd0;
  localparam logic [1:0] OUT_NOT_FOUND = 2'd1;
  localparam logic [1:0] OUT_FULL      = 2'd2;
  localparam logic [1:0] OUT_EXISTS    = 2'd3;

  localparam logic [1:0] ROLE_ADMIN   = 2'd0;
  localparam logic [1:0] ROLE_KNOWN   = 2'd1;
  localparam logic [1:0] ROLE_UNKNOWN = 2'd2;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  status;
    logic [31:0] code;
  } row_t;

  localparam row_t EMPTY_ROW = '{id: 8'hFF, status: 8'hFF, code: 32'hFFFF_FFFF};

  typedef struct packed {
    logic [1:0] outcome;
    logic [1:0] role;
    logic [7:0] status_value;
    logic [3:0] slot;
    logic [7:0] user_id;
  } rsp_t;

endpackage

// ===== src/act_if.sv =====
interface act_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] code;

  modport source (output valid, output op, output code, input ready);
  modport sink   (input valid, input op, input code, output ready);
endinterface

interface act_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] outcome;
  logic [1:0] role;
  logic [7:0] status_value;
  logic [3:0] slot;
  logic [7:0] user_id;

  modport source (output valid, output outcome, output role, output status_value,
                  output slot, output user_id, input ready);
  modport sink   (input valid, input outcome, input role, input status_value,
                  input slot, input user_id, output ready);
endinterface

interface act_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/act_cell.sv =====
module act_cell (
  input  logic         clk,
  input  logic         rst,
  input  logic         shift,
  input  act_pkg::row_t d,
  output act_pkg::row_t q
);
  import act_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= EMPTY_ROW;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== src/act_ctrl.sv =====
module act_ctrl #(
  parameter int ENTRIES = act_pkg::ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  logic [2:0]    req_op,
  input  logic [31:0]   req_code,
  input  logic [31:0]   admin_code,
  input  act_pkg::row_t head,
  output act_pkg::row_t wb,
  output logic          shift,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output act_pkg::rsp_t rsp
);
  import act_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  typedef enum logic [2:0] {S_IDLE, S_WALK, S_DECIDE, S_FILL, S_FINISH} state_t;

  state_t           state;
  op_t              op_r;
  logic [31:0]      code_r;
  logic [IDX_W-1:0] step;
  logic             found_m;
  logic             found_e;
  logic [IDX_W-1:0] m_idx;
  logic [IDX_W-1:0] e_idx;
  logic [7:0]       m_id;
  logic [7:0]       m_status;
  logic [7:0]       e_id;
  logic [7:0]       last_id;
  rsp_t             res;
  rsp_t             res_next;
  logic             fill_row;
  logic             hit;
  logic             empty_hit;

  assign req_ready = (state == S_IDLE);
  assign shift     = (state == S_WALK) || (state == S_FILL);

  always_comb begin
    hit       = (head.id != EMPTY_BYTE) && (head.code == code_r) && !found_m;
    empty_hit = (head.id == EMPTY_BYTE) && !found_e;
    wb        = head;
    if (state == S_WALK) begin
      if (op_r == OP_CLEAR) begin
        wb = EMPTY_ROW;
      end else if (hit && op_r == OP_REMOVE) begin
        wb = EMPTY_ROW;
      end else if (hit && op_r == OP_TOGGLE) begin
        if (head.status == CHAR_ZERO) begin
          wb.status = CHAR_ONE;
        end else if (head.status == CHAR_ONE) begin
          wb.status = CHAR_ZERO;
        end
      end
    end else if (state == S_FILL && step == e_idx) begin
      wb = '{id: e_id, status: CHAR_ONE, code: code_r};
    end
  end

  // result of a finished walk, and whether an enroll needs the fill pass
  always_comb begin
    res_next = '0;
    fill_row = 1'b0;
    case (op_r)
      OP_ENROLL: begin
        if (!found_e) begin
          res_next.outcome = OUT_FULL;
        end else if (found_m && code_r != admin_code) begin
          res_next.outcome      = OUT_EXISTS;
          res_next.status_value = m_status;
          res_next.slot         = 4'(m_idx);
          res_next.user_id      = m_id;
        end else begin
          res_next.status_value = CHAR_ONE;
          res_next.slot         = 4'(e_idx);
          res_next.user_id      = e_id;
          fill_row              = 1'b1;
        end
      end
      OP_REMOVE, OP_TOGGLE, OP_QUERY: begin
        if (found_m) begin
          res_next.status_value = m_status;
          res_next.slot         = 4'(m_idx);
          res_next.user_id      = m_id;
        end else begin
          res_next.outcome = OUT_NOT_FOUND;
        end
      end
      OP_CLASS: begin
        if (code_r == admin_code) begin
          res_next.role = ROLE_ADMIN;
        end else if (found_m) begin
          res_next.role         = ROLE_KNOWN;
          res_next.status_value = m_status;
          res_next.slot         = 4'(m_idx);
          res_next.user_id      = m_id;
        end else begin
          res_next.outcome = OUT_NOT_FOUND;
          res_next.role    = ROLE_UNKNOWN;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_FINISH && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_r    <= op_t'(req_op);
            code_r  <= req_code;
            step    <= '0;
            found_m <= 1'b0;
            found_e <= 1'b0;
            last_id <= EMPTY_BYTE;
            state   <= S_WALK;
          end
        end
        S_WALK: begin
          last_id <= head.id;
          if (hit) begin
            found_m  <= 1'b1;
            m_idx    <= step;
            m_id     <= head.id;
            m_status <= wb.status;
          end
          if (empty_hit) begin
            found_e <= 1'b1;
            e_idx   <= step;
            // row 0 starts the id sequence, later rows follow their predecessor
            e_id    <= (step == '0) ? CHAR_ONE : 8'(last_id + 8'd1);
          end
          if (step == LAST) begin
            step  <= '0;
            state <= S_DECIDE;
          end else begin
            step <= step + IDX_W'(1);
          end
        end
        S_DECIDE: begin
          res   <= res_next;
          state <= fill_row ? S_FILL : S_FINISH;
        end
        S_FILL: begin
          if (step == LAST) begin
            step  <= '0;
            state <= S_FINISH;
          end else begin
            step <= step + IDX_W'(1);
          end
        end
        S_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "access_credential_table_core_assert.svh"

  `ACT_ASSERT_NEXT(a_accept_walk, req_valid && req_ready, state == S_WALK, "no walk after accept")
  `ACT_ASSERT_NOW(a_idle_no_shift, req_ready, !shift, "ring moved while idle")
  `ACT_ASSERT_NEXT(a_full_no_fill, state == S_DECIDE && !found_e, state == S_FINISH, "fill on full")
  `ACT_ASSERT_NEXT(a_walk_aligned, state == S_DECIDE, step == '0, "ring misaligned")

endmodule

// ===== src/access_credential_table_core.sv =====
// Flow: an accepted transaction walks one full rotation of the row ring before its result
//   is valid; an enroll that writes a row takes a second ring rotation to land the new row.
// Throughput: one transaction in flight; the next is taken the cycle after the result
//   is loaded into the output register. Set by the rotation of the row ring.
// Reset: all rows empty (every byte 0xFF) at once, admin code 0x30303030, no result.
module access_credential_table_core #(
  parameter int ENTRIES = act_pkg::ENTRIES_DEF
) (
  input logic        clk,
  input logic        rst,
  act_req_if.sink    req,
  act_rsp_if.source  rsp,
  act_cfg_if.sink    cfg
);
  import act_pkg::*;

  logic [31:0] admin_code;
  row_t        rows [ENTRIES];
  row_t        wb;
  logic        shift;
  rsp_t        rsp_d;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      admin_code <= ADMIN_RESET;
    end else if (cfg.valid) begin
      admin_code <= cfg.data;
    end
  end

  // row 0 sits at the head; the ring rotates toward it, the head row re-enters at the tail
  for (genvar i = 0; i < ENTRIES; i++) begin : g_ring
    if (i == ENTRIES - 1) begin : g_tail
      act_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(wb), .q(rows[i]));
    end else begin : g_body
      act_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(rows[i+1]), .q(rows[i]));
    end
  end

  act_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_op     (req.op),
    .req_code   (req.code),
    .admin_code (admin_code),
    .head       (rows[0]),
    .wb         (wb),
    .shift      (shift),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp        (rsp_d)
  );

  assign rsp.outcome      = rsp_d.outcome;
  assign rsp.role         = rsp_d.role;
  assign rsp.status_value = rsp_d.status_value;
  assign rsp.slot         = rsp_d.slot;
  assign rsp.user_id      = rsp_d.user_id;

endmodule
